[hdl/smf_pkg.sv]
`timescale 1ns / 1ps
// Package for the sliding median filter: sample width, default window length
// and the payload types of the input and result channels. No dependencies.

package smf_pkg;

    // Width of one sample and of one filtered result.
    localparam int SAMPLE_BITS = 16;

    // Default window length (odd; an even value acts as one more).
    localparam int WINDOW_DEF = 9;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    // Payload of one input transaction.
    typedef struct packed {
        sample_t sample;
        logic    is_last;
    } in_item_t;

    // Payload of one result transaction.
    typedef struct packed {
        sample_t filtered;
        logic    end_of_seq;
    } out_item_t;

endpackage

[hdl/sliding_median_filter_core.sv]
`timescale 1ns / 1ps
// Sliding-window median filter core: sample history, rank-based median and
// end-of-sequence flush sequencer. Depends on smf_pkg.
//
// Usage:
// - Input channel (s_valid/s_ready/s_data) takes one signed sample per
//   transaction; is_last marks the final sample of a sequence.
// - Result channel (m_valid/m_ready/m_data) gives the window median of the
//   sample WINDOW/2 positions back, or a copy of it near either end of the
//   sequence; end_of_seq marks the final result of a sequence.
// - Throughput: one sample per cycle while the receiver keeps up. A sample
//   marked is_last causes up to WINDOW/2 + 1 results, one per cycle while
//   the receiver is ready, and the input waits while that flush drains.
// - m_valid rises once the causing transaction has passed the comparison
//   register and then the result register; results trail the samples by
//   WINDOW/2 transactions.
// - The median is found in one pass: all pairwise comparisons of the window
//   are registered, then each sample's rank is counted and the one of middle
//   rank is selected into the result register.
// - Reset (aresetn low, synchronous) empties the history count, the pending
//   flush and the result register; a new sequence starts afterwards.
// - On a receiver stall the result register holds its transaction; samples
//   are taken until one with pending work is held in the comparison register.

module sliding_median_filter_core #(
    parameter int WINDOW = smf_pkg::WINDOW_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  smf_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output smf_pkg::out_item_t  m_data
);

    localparam int HALF  = WINDOW / 2;
    localparam int DEPTH = 2 * HALF;
    localparam int TAPS  = DEPTH + 1;
    localparam int IW    = $clog2(TAPS);

    // Sample history: entry DEPTH-1 is the newest held sample.
    smf_pkg::sample_t store_reg [DEPTH];
    logic [IW-1:0]    seen_reg;
    logic [IW-1:0]    seen_next;

    // Window snapshot of the accepted transaction, indexed by age (0 = current).
    smf_pkg::sample_t hist_next  [TAPS];
    smf_pkg::sample_t hist_reg   [TAPS];
    logic [TAPS-1:0]  before_next [TAPS];
    logic [TAPS-1:0]  before_reg  [TAPS];

    // Pending work for the snapshot.
    typedef struct packed {
        logic          busy;
        logic          dly_pend;
        logic          use_med;
        logic          flush;
        logic [IW-1:0] age;
    } job_t;

    job_t job_reg;
    job_t job_new;
    job_t job_next;

    logic                s_accept;
    logic                out_load_ok;
    logic                job_step;
    logic                job_done;
    logic                m_valid_reg;
    logic                m_valid_next;
    smf_pkg::out_item_t  m_data_reg;
    smf_pkg::out_item_t  res_item;
    smf_pkg::sample_t    median;
    logic [IW-1:0]       rank [TAPS];

    // Handshake decisions.
    assign out_load_ok = !m_valid_reg || m_ready;
    assign job_step    = job_reg.busy && out_load_ok;
    assign s_ready     = !job_reg.busy || (job_step && job_done);
    assign s_accept    = s_valid && s_ready;

    // Window snapshot with the current sample at age zero.
    always_comb begin
        hist_next[0] = s_data.sample;
        for (int d = 1; d < TAPS; d++) begin
            hist_next[d] = store_reg[DEPTH-d];
        end
    end

    // Pairwise order: bit j of row i is set when sample j sorts before sample i.
    // Equal values are ordered by position so that every rank is unique.
    always_comb begin
        for (int i = 0; i < TAPS; i++) begin
            for (int j = 0; j < TAPS; j++) begin
                before_next[i][j] = (j != i) &&
                    ((hist_next[j] < hist_next[i]) ||
                     ((hist_next[j] == hist_next[i]) && (j < i)));
            end
        end
    end

    // Work that the accepted transaction leaves for the sequencer.
    always_comb begin
        job_new.dly_pend = (seen_reg >= IW'(HALF));
        job_new.use_med  = (seen_reg == IW'(DEPTH));
        job_new.flush    = s_data.is_last;
        job_new.age      = (seen_reg < IW'(HALF)) ? seen_reg : IW'(HALF - 1);
        job_new.busy     = job_new.dly_pend || s_data.is_last;
    end

    // Next history count: cleared by is_last, else saturating at the history depth.
    always_comb begin
        if (s_data.is_last) begin
            seen_next = '0;
        end else if (seen_reg < IW'(DEPTH)) begin
            seen_next = seen_reg + 1'b1;
        end else begin
            seen_next = IW'(DEPTH);
        end
    end

    // Rank of each snapshot sample and selection of the middle one.
    always_comb begin
        median = '0;
        for (int i = 0; i < TAPS; i++) begin
            rank[i] = '0;
            for (int j = 0; j < TAPS; j++) begin
                rank[i] = rank[i] + IW'(before_reg[i][j]);
            end
            if (rank[i] == IW'(HALF)) begin
                median = median | hist_reg[i];
            end
        end
    end

    // Result of the current sequencer step: the delayed output first, then
    // the flushed copies from oldest to the current sample.
    always_comb begin
        if (job_reg.dly_pend) begin
            res_item.filtered   = job_reg.use_med ? median : hist_reg[HALF];
            res_item.end_of_seq = 1'b0;
            job_done            = !job_reg.flush;
        end else begin
            res_item.filtered   = hist_reg[job_reg.age];
            res_item.end_of_seq = (job_reg.age == '0);
            job_done            = (job_reg.age == '0);
        end
    end

    // Sequencer state for the next cycle.
    always_comb begin
        job_next = job_reg;
        if (s_accept) begin
            job_next = job_new;
        end else if (job_step) begin
            if (job_done) begin
                job_next.busy = 1'b0;
            end else if (job_reg.dly_pend) begin
                job_next.dly_pend = 1'b0;
            end else begin
                job_next.age = job_reg.age - 1'b1;
            end
        end
    end

    // Result register valid flag.
    always_comb begin
        if (job_step) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg    <= '0;
            job_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_accept) begin
                seen_reg <= seen_next;
            end
            job_reg     <= job_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload: history shift, snapshot, comparison matrix and result.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            for (int k = 0; k < DEPTH - 1; k++) begin
                store_reg[k] <= store_reg[k+1];
            end
            store_reg[DEPTH-1] <= s_data.sample;
            hist_reg           <= hist_next;
            before_reg         <= before_next;
        end
        if (job_step) begin
            m_data_reg <= res_item;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[hdl/smf_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for sliding_median_filter_core, attached with a bind.
// Depends on smf_pkg and on the core's port list.

module smf_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input smf_pkg::in_item_t  s_data,
    input logic               m_valid,
    input logic               m_ready,
    input smf_pkg::out_item_t m_data
);

    // A stalled result transaction keeps its valid and its payload.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Reset leaves no result pending and the input open.
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("state after reset is not empty");

    // With the result register empty and no transaction taken in this cycle or
    // the one before, no result appears.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid && !(s_valid && s_ready) && !$past(s_valid && s_ready) |=> !m_valid)
        else $error("result appeared without a cause");

    // The input is never refused while nothing is pending at all.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid && !(s_valid && s_ready) && !$past(s_valid && s_ready) |=> s_ready)
        else $error("input blocked while idle");

endmodule

bind sliding_median_filter_core smf_checker u_smf_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

[verif/sliding_median_filter_core_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for sliding_median_filter_core: directed and random sample
// sequences with random idling on both channels, checked against a built-in predictor.
// Depends on smf_pkg and the core RTL.

module sliding_median_filter_core_test;

    localparam int HALF       = smf_pkg::WINDOW_DEF / 2;
    localparam int DEPTH      = 2 * HALF;
    localparam int LONG_HOLD  = 60;
    localparam int DRAIN_WAIT = 16;

    typedef enum int {STYLE_FULL, STYLE_NARROW, STYLE_EXTREME} sample_style_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    smf_pkg::in_item_t   s_data;
    logic                m_valid;
    logic                m_ready;
    smf_pkg::out_item_t  m_data;

    // Predictor state: previous samples (newest at the top) and held count.
    smf_pkg::sample_t    history [DEPTH];
    int                  held_count = 0;
    smf_pkg::out_item_t  pending_results [$];

    // Run control and statistics.
    bit         idle_on = 1'b1;
    bit         long_hold_pending = 1'b0;
    int         fail_count = 0;
    int         samples_sent = 0;
    int         sequences_sent = 0;
    int         results_checked = 0;
    int         long_holds_done = 0;

    sliding_median_filter_core uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #6 aclk = ~aclk;

    // Median of the held window plus the current sample.
    function automatic smf_pkg::sample_t window_median(smf_pkg::sample_t cur);
        smf_pkg::sample_t vals [DEPTH+1];
        smf_pkg::sample_t tmp;
        for (int i = 0; i < DEPTH; i++) begin
            vals[i] = history[i];
        end
        vals[DEPTH] = cur;
        for (int i = 0; i < DEPTH; i++) begin
            for (int j = 0; j < DEPTH - i; j++) begin
                if (vals[j] > vals[j+1]) begin
                    tmp       = vals[j];
                    vals[j]   = vals[j+1];
                    vals[j+1] = tmp;
                end
            end
        end
        return vals[HALF];
    endfunction

    // Work out the results caused by one accepted sample and update the history.
    function automatic void compute_filter_results(smf_pkg::in_item_t item);
        int                  n;
        int                  d;
        smf_pkg::out_item_t  r;
        n = held_count;
        if (n >= HALF) begin
            r.filtered   = (n == DEPTH) ? window_median(item.sample) : history[DEPTH-HALF];
            r.end_of_seq = 1'b0;
            pending_results = {pending_results, r};
        end
        // At the end of a sequence the held samples are flushed as copies, oldest first.
        if (item.is_last) begin
            d = (n < HALF) ? n : HALF - 1;
            for (int k = d; k >= 0; k--) begin
                r.filtered   = (k == 0) ? item.sample : history[DEPTH-k];
                r.end_of_seq = (k == 0);
                pending_results = {pending_results, r};
            end
        end
        for (int k = 0; k < DEPTH - 1; k++) begin
            history[k] = history[k+1];
        end
        history[DEPTH-1] = item.sample;
        if (item.is_last) begin
            held_count = 0;
        end else begin
            held_count = (n < DEPTH) ? n + 1 : DEPTH;
        end
    endfunction

    // Predict on every accepted input transaction and check every accepted result.
    always @(posedge aclk) begin
        smf_pkg::out_item_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                compute_filter_results(s_data);
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $error("Unexpected result: filtered %0d, end_of_seq %0b",
                           m_data.filtered, m_data.end_of_seq);
                    fail_count++;
                end else begin
                    want = pending_results[0];
                    pending_results.delete(0);
                    results_checked++;
                    if (m_data.filtered !== want.filtered) begin
                        $error("filtered mismatch: expected %0d, actual %0d",
                               want.filtered, m_data.filtered);
                        fail_count++;
                    end
                    if (m_data.end_of_seq !== want.end_of_seq) begin
                        $error("end_of_seq mismatch: expected %0b, actual %0b",
                               want.end_of_seq, m_data.end_of_seq);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Result receiver: random stall bursts, plus one long hold on request.
    initial begin
        int n;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            n = 0;
            if (long_hold_pending) begin
                n = LONG_HOLD;
                long_hold_pending = 1'b0;
                long_holds_done++;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                n = $urandom_range(1, 9);
            end
            if (n > 0) begin
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    // Offer one sample and wait until the core takes it.
    task automatic send_sample(input smf_pkg::sample_t smp, input logic last);
        smf_pkg::in_item_t item;
        item.sample  = smp;
        item.is_last = last;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        samples_sent++;
    endtask

    function automatic smf_pkg::sample_t pick_sample(sample_style_t style);
        smf_pkg::sample_t v;
        case (style)
            STYLE_NARROW: v = smf_pkg::sample_t'($urandom_range(0, 8) - 4);
            STYLE_EXTREME: begin
                case ($urandom_range(0, 3))
                    0:       v = 16'h8000;
                    1:       v = 16'h7FFF;
                    2:       v = 16'hFFFF;
                    default: v = 16'h0000;
                endcase
            end
            default: v = smf_pkg::sample_t'($urandom);
        endcase
        return v;
    endfunction

    task automatic send_sequence(input int len, input sample_style_t style);
        for (int k = 0; k < len; k++) begin
            send_sample(pick_sample(style), k == len - 1);
        end
        sequences_sent++;
    endtask

    // Sequences shorter than half a window, one just past it, and a sequence longer
    // than a full window, built mostly from the extreme codes.
    task automatic test_directed_edges();
        smf_pkg::sample_t full_seq [12];
        full_seq = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h7FFF,
                     16'h8000, 16'h5555, 16'hAAAA, 16'h7FFF, 16'h8000, 16'h0000};
        send_sample(16'h8000, 1'b1);
        sequences_sent++;
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'hFFFF, 1'b1);
        sequences_sent++;
        send_sample(16'h0001, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h5555, 1'b0);
        send_sample(16'hAAAA, 1'b1);
        sequences_sent++;
        for (int k = 0; k < 12; k++) begin
            send_sample(full_seq[k], k == 11);
        end
        sequences_sent++;
    endtask

    // Random sequences; lengths lean toward the window boundaries.
    task automatic test_random_sequences(input int target);
        int            sent;
        int            len;
        sample_style_t style;
        sent = 0;
        while (sent < target) begin
            case ($urandom_range(0, 9)) inside
                0:       len = $urandom_range(25, 60);
                [1:3]:   len = $urandom_range(1, DEPTH + 1);
                default: len = $urandom_range(DEPTH + 2, 24);
            endcase
            style = sample_style_t'($urandom_range(0, 2));
            send_sequence(len, style);
            sent += len;
        end
    endtask

    // Hold the receiver off while samples keep coming, so the core stalls its input.
    task automatic test_backpressure();
        bit saved_idle;
        saved_idle        = idle_on;
        idle_on           = 1'b0;
        long_hold_pending = 1'b1;
        send_sequence(40, STYLE_FULL);
        idle_on = saved_idle;
    endtask

    // Main sequence of tests.
    initial begin
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        for (int i = 0; i < DEPTH; i++) begin
            history[i] = '0;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_edges();
        test_random_sequences(150);
        test_backpressure();
        test_random_sequences(150);
        idle_on = 1'b0;
        test_random_sequences(60);
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $error("%0d expected results never arrived", pending_results.size());
            fail_count++;
        end

        $display("Sent %0d samples in %0d sequences; checked %0d results.",
                 samples_sent, sequences_sent, results_checked);
        $display("Receiver long holds: %0d; random idling on both channels until the last part.",
                 long_holds_done);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

[sim.f]
hdl/smf_pkg.sv
hdl/sliding_median_filter_core.sv
hdl/smf_checker.sv
verif/sliding_median_filter_core_test.sv
